FILE: rtl/core/tcs_pkg.sv
package tcs_pkg;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 19;
  localparam int POS_EXT_W  = 24;
  localparam int ERR_W      = 17;
  localparam int DSUM_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Division by three of a sum of three 8-bit differences: x * 683 >> 11.
  localparam logic [DSUM_W-1:0] THIRD_MUL   = 10'd683;
  localparam int                THIRD_SHIFT = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_LUMA_THR   = 3'd1,
    REG_CHROMA_THR = 3'd2,
    REG_ERR_LIMIT  = 3'd3,
    REG_ERR_BIAS   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] i;
    logic [PIX_W-1:0] q;
  } yiq_t;

endpackage

FILE: rtl/core/tcs_if.sv
interface tcs_pix_in_if import tcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pixel_position;
  logic [PIX_W-1:0] luma_in;
  logic [PIX_W-1:0] inphase_in;
  logic [PIX_W-1:0] quadrature_in;

  modport source (output valid, pixel_position, luma_in, inphase_in, quadrature_in,
                  input ready);
  modport sink   (input valid, pixel_position, luma_in, inphase_in, quadrature_in,
                  output ready);
endinterface

interface tcs_pix_out_if import tcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma_out;
  logic [PIX_W-1:0] inphase_out;
  logic [PIX_W-1:0] quadrature_out;

  modport source (output valid, luma_out, inphase_out, quadrature_out, input ready);
  modport sink   (input valid, luma_out, inphase_out, quadrature_out, output ready);
endinterface

interface tcs_cfg_if import tcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/tcs_ram.sv
module tcs_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/core/temporal_chroma_stabilizer_top.sv
// Channel    Role    Payload                                         Request taken when
// cfg_i      sink    index (3 bits), data (16 bits)                  valid && ready (ready is 1)
// pix_i      sink    pixel_position, luma_in, inphase_in, quadrature_in  valid && ready
// pix_o      source  luma_out, inphase_out, quadrature_out           valid && ready
//
// One request enters per cycle unless stalled, and its result passes through a RAM read,
// a compare stage, an update stage, four stages of a two-bit-per-stage divider and the
// output register. A request stalls while an earlier request to the same position is still
// between the read and the write-back, since the per-position RAM is read and written once.
// After reset a clearing pass writes zeros over all MAX_PIXELS entries of the state RAM
// (524288 by default), one entry per cycle; no request is taken meanwhile, though
// configuration writes are. Each stage holds while the next is full, so a stall on pix_o
// fills the empty stages behind it before pix_i is held off.
module temporal_chroma_stabilizer_top import tcs_pkg::*; #(
  parameter int MAX_PIXELS = 524288,
  parameter int COUNT_MAX  = 255
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tcs_cfg_if.sink       cfg_i,
  tcs_pix_in_if.sink    pix_i,
  tcs_pix_out_if.source pix_o
);
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(COUNT_MAX + 1);
  localparam int SW = $clog2(255 * COUNT_MAX + 1);
  localparam int DW = CW + PIX_W;
  // Stages 0..6 reach the write-back; stage 7 is the output register.
  localparam int NST = 8;
  localparam int NWB = 7;

  // Everything kept for one position.
  typedef struct packed {
    logic [SW-1:0]    sy;
    logic [SW-1:0]    si;
    logic [SW-1:0]    sq;
    logic [CW-1:0]    cnt;
    logic [ERR_W-1:0] err;
    yiq_t             raw;
    yiq_t             avg;
  } entry_t;

  localparam int EW = $bits(entry_t);

  function automatic logic [PIX_W-1:0] absd(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // One restoring division step: returns the quotient bit above the new remainder.
  function automatic logic [SW:0] dstep(logic [SW-1:0] rem, logic [CW-1:0] n, int k);
    logic [DW-1:0] r;
    logic [DW-1:0] t;
    r = DW'(rem);
    t = DW'(n) << k;
    if (r >= t) begin
      return {1'b1, SW'(r - t)};
    end
    return {1'b0, rem};
  endfunction

  // Configuration registers.
  logic             en_q;
  logic [PIX_W-1:0] luma_thr_q;
  logic [PIX_W-1:0] chroma_thr_q;
  logic [15:0]      err_limit_q;
  logic [PIX_W-1:0] err_bias_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q         <= 1'b1;
      luma_thr_q   <= 8'd5;
      chroma_thr_q <= 8'd30;
      err_limit_q  <= 16'd15;
      err_bias_q   <= 8'd5;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_ENABLE:     en_q         <= cfg_i.data[0];
        REG_LUMA_THR:   luma_thr_q   <= cfg_i.data[PIX_W-1:0];
        REG_CHROMA_THR: chroma_thr_q <= cfg_i.data[PIX_W-1:0];
        REG_ERR_LIMIT:  err_limit_q  <= cfg_i.data;
        REG_ERR_BIAS:   err_bias_q   <= cfg_i.data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass over the state RAM after reset.
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(MAX_PIXELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Pipeline control. A stage is free when empty or when its content moves on.
  logic [NST-1:0] v_q;
  logic [NST-1:0] free;
  logic [AW-1:0]  addr_q [NWB];
  logic [NWB-1:0] we_q;

  always_comb begin
    free[NST-1] = !v_q[NST-1] || pix_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      free[k] = !v_q[k] || free[k+1];
    end
  end

  // Incoming request.
  logic [POS_EXT_W-1:0] pos_ext;
  logic                 in_range;
  logic [AW-1:0]        in_addr;
  logic                 in_we;
  logic                 hazard;
  logic                 in_acc;

  assign pos_ext  = POS_EXT_W'(pix_i.pixel_position);
  assign in_range = {1'b0, pos_ext} < (POS_EXT_W + 1)'(MAX_PIXELS);
  assign in_addr  = pos_ext[AW-1:0];
  assign in_we    = en_q && in_range;

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < NWB; k++) begin
      if (v_q[k] && we_q[k] && addr_q[k] == in_addr) begin
        hazard = in_we;
      end
    end
  end

  assign pix_i.ready = free[0] && !hazard && !clr_busy_q;
  assign in_acc      = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (free[0]) begin
        v_q[0] <= in_acc;
      end
      for (int k = 1; k < NST; k++) begin
        if (free[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[0]) begin
      addr_q[0] <= in_addr;
      we_q[0]   <= in_we;
    end
    for (int k = 1; k < NWB; k++) begin
      if (free[k]) begin
        addr_q[k] <= addr_q[k-1];
        we_q[k]   <= we_q[k-1];
      end
    end
  end

  // State RAM.
  logic          pipe_wr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        wb_entry;
  logic [EW-1:0] ram_rdata;

  assign pipe_wr   = v_q[NWB-1] && we_q[NWB-1] && free[NWB];
  assign ram_we    = clr_busy_q || pipe_wr;
  assign ram_waddr = clr_busy_q ? clr_addr_q : addr_q[NWB-1];
  assign ram_wdata = clr_busy_q ? '0 : wb_entry;

  tcs_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PIXELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // Stage 0: the pixel waits for its stored entry.
  yiq_t s1_pix_q;

  always_ff @(posedge clk_i) begin
    if (free[0]) begin
      s1_pix_q <= '{y: pix_i.luma_in, i: pix_i.inphase_in, q: pix_i.quadrature_in};
    end
  end

  // Stage 1: differences against both stored pixels and the match decision.
  entry_t            ent;
  logic              match;
  logic [DSUM_W-1:0] dsum;
  yiq_t              s2_pix_q;
  entry_t            s2_ent_q;
  logic              s2_match_q;
  logic [DSUM_W-1:0] s2_dsum_q;

  always_comb begin
    logic [PIX_W-1:0] dy, di, dq;
    ent   = entry_t'(ram_rdata);
    dy    = absd(ent.avg.y, s1_pix_q.y);
    di    = absd(ent.avg.i, s1_pix_q.i);
    dq    = absd(ent.avg.q, s1_pix_q.q);
    match = absd(ent.raw.y, s1_pix_q.y) <= luma_thr_q && dy <= luma_thr_q &&
            absd(ent.raw.i, s1_pix_q.i) <= chroma_thr_q &&
            absd(ent.raw.q, s1_pix_q.q) <= chroma_thr_q &&
            di <= chroma_thr_q && dq <= chroma_thr_q;
    dsum  = DSUM_W'(dy) + DSUM_W'(di) + DSUM_W'(dq);
  end

  always_ff @(posedge clk_i) begin
    if (free[1]) begin
      s2_pix_q   <= s1_pix_q;
      s2_ent_q   <= ent;
      s2_match_q <= match;
      s2_dsum_q  <= dsum;
    end
  end

  // Stage 2: error score update and the restart decision. Pass-through requests
  // take the pixel as a one-sample sum, so the divider returns it unchanged.
  logic [SW-1:0]    s3_sy_q, s3_si_q, s3_sq_q;
  logic [CW-1:0]    s3_cnt_q;
  logic [ERR_W-1:0] s3_err_q;
  yiq_t             s3_raw_q;

  always_ff @(posedge clk_i) begin
    logic [2*DSUM_W-1:0] prod;
    logic [PIX_W-1:0]    mean;
    logic [PIX_W-1:0]    add;
    logic [ERR_W-1:0]    err_sum;
    logic                keep;
    if (free[2]) begin
      prod    = (2*DSUM_W)'(s2_dsum_q) * (2*DSUM_W)'(THIRD_MUL);
      mean    = prod[THIRD_SHIFT +: PIX_W];
      add     = (mean > err_bias_q) ? mean - err_bias_q : '0;
      err_sum = s2_ent_q.err + ERR_W'(add);
      keep    = we_q[1] && s2_match_q && s2_ent_q.cnt < CW'(COUNT_MAX) &&
                err_sum < ERR_W'(err_limit_q);
      if (keep) begin
        s3_sy_q  <= s2_ent_q.sy + SW'(s2_pix_q.y);
        s3_si_q  <= s2_ent_q.si + SW'(s2_pix_q.i);
        s3_sq_q  <= s2_ent_q.sq + SW'(s2_pix_q.q);
        s3_cnt_q <= s2_ent_q.cnt + 1'b1;
        s3_err_q <= err_sum;
      end else begin
        s3_sy_q  <= SW'(s2_pix_q.y);
        s3_si_q  <= SW'(s2_pix_q.i);
        s3_sq_q  <= SW'(s2_pix_q.q);
        s3_cnt_q <= CW'(1);
        s3_err_q <= '0;
      end
      s3_raw_q <= s2_pix_q;
    end
  end

  // Stages 3 to 6: sum / count, two quotient bits per stage. Every sum stays
  // below 256 times its count, so eight quotient bits suffice.
  logic [SW-1:0]    d_sum_q [4][3];
  logic [SW-1:0]    d_rem_q [4][3];
  logic [PIX_W-1:0] d_quo_q [4][3];
  logic [CW-1:0]    d_cnt_q [4];
  logic [ERR_W-1:0] d_err_q [4];
  yiq_t             d_raw_q [4];

  always_ff @(posedge clk_i) begin
    logic [SW-1:0]    rem;
    logic [PIX_W-1:0] quo;
    logic [CW-1:0]    n;
    logic [SW:0]      st;
    for (int j = 0; j < 4; j++) begin
      if (free[3+j]) begin
        n = (j == 0) ? s3_cnt_q : d_cnt_q[(j == 0) ? 0 : j-1];
        for (int c = 0; c < 3; c++) begin
          if (j == 0) begin
            rem = (c == 0) ? s3_sy_q : (c == 1) ? s3_si_q : s3_sq_q;
            quo = '0;
            d_sum_q[j][c] <= rem;
          end else begin
            rem = d_rem_q[j-1][c];
            quo = d_quo_q[j-1][c];
            d_sum_q[j][c] <= d_sum_q[j-1][c];
          end
          st  = dstep(rem, n, 7 - 2*j);
          quo[7-2*j] = st[SW];
          st  = dstep(st[SW-1:0], n, 6 - 2*j);
          quo[6-2*j] = st[SW];
          d_rem_q[j][c] <= st[SW-1:0];
          d_quo_q[j][c] <= quo;
        end
        d_cnt_q[j] <= n;
        if (j == 0) begin
          d_err_q[j] <= s3_err_q;
          d_raw_q[j] <= s3_raw_q;
        end else begin
          d_err_q[j] <= d_err_q[j-1];
          d_raw_q[j] <= d_raw_q[j-1];
        end
      end
    end
  end

  // Write-back as the request moves into the output register.
  assign wb_entry = '{
    sy:  d_sum_q[3][0],
    si:  d_sum_q[3][1],
    sq:  d_sum_q[3][2],
    cnt: d_cnt_q[3],
    err: d_err_q[3],
    raw: d_raw_q[3],
    avg: '{y: d_quo_q[3][0], i: d_quo_q[3][1], q: d_quo_q[3][2]}
  };

  // Stage 7: output register.
  yiq_t out_q;

  always_ff @(posedge clk_i) begin
    if (free[NST-1]) begin
      out_q <= wb_entry.avg;
    end
  end

  assign pix_o.valid          = v_q[NST-1];
  assign pix_o.luma_out       = out_q.y;
  assign pix_o.inphase_out    = out_q.i;
  assign pix_o.quadrature_out = out_q.q;

  // No request is taken while the clearing pass owns the RAM write port.
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !pix_i.ready)
    else $error("request taken during clearing pass");

  // The divider never sees a zero count.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NWB-1] |-> d_cnt_q[3] != '0)
    else $error("zero sample count at write-back");

  // A kept error score is always below the limit; otherwise it was restarted.
  a_err_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] && we_q[2] |-> (s3_err_q < ERR_W'(err_limit_q)) || (s3_err_q == '0))
    else $error("error score kept at or above limit");

  // No position is read while a write to it is still pending.
  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_wr |=> !(v_q[0] && we_q[0] && addr_q[0] == $past(addr_q[NWB-1]) &&
                  $past(v_q[0] && we_q[0] && addr_q[0] == addr_q[NWB-1])))
    else $error("read overlapped a pending write to the same position");

endmodule
